// File: hw/rtl/ramped_drive_with_current_limit_pi_core_assert.svh
// Assertion macros for the ramped drive core, switched off by defining ASSERT_OFF
`ifndef RAMPED_DRIVE_WITH_CURRENT_LIMIT_PI_CORE_ASSERT_SVH
`define RAMPED_DRIVE_WITH_CURRENT_LIMIT_PI_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// check a consequence in the same cycle as its cause
`define RDCL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdcl assertion failed");
// check a consequence in the cycle after its cause
`define RDCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdcl assertion failed");
`else
`define RDCL_ASSERT_SAME(label, clk, rst, ante, cons)
`define RDCL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/rdcl_pkg.sv
// Shared types, widths, register codes and saturation helpers of the ramped drive core
`timescale 1ns / 1ps

package rdcl_pkg;

   // lanes and fixed-point format
   localparam int CHANNELS  = 3;
   localparam int FRAC      = 16;
   localparam int FRAC_MASK = 2**FRAC - 1;

   // request and response field widths
   localparam int REF_W  = 12;
   localparam int CUR_W  = 13;
   localparam int DUTY_W = 12;

   // per-lane state widths
   localparam int ACC_W  = 32;
   localparam int INT_W  = 40;
   localparam int CORR_W = 16;

   // configuration register widths
   localparam int RAMP_GAIN_W = 16;
   localparam int GAIN_W      = 19;
   localparam int LIMIT_W     = 12;
   localparam int CSR_DATA_W  = 19;
   localparam int CSR_INDEX_W = 3;

   // datapath widths
   localparam int LIM_W       = CUR_W + 1;
   localparam int ERR_W       = LIM_W + GAIN_W + 1;
   localparam int DIFF_W      = CORR_W + GAIN_W + 1;
   localparam int MUL_A_W     = DIFF_W;
   localparam int MUL_B_W     = GAIN_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_INT_W   = ACC_W + 1 - FRAC;
   localparam int CORR_WIDE_W = INT_W + 1 - FRAC;
   localparam int DUTY_SUM_W  = CORR_W + 1;

   // saturation bounds
   localparam int REF_MAX  = 2**(REF_W - 1) - 1;
   localparam int REF_MIN  = -REF_MAX - 1;
   localparam int DUTY_MAX = 2**(DUTY_W - 1) - 1;
   localparam int DUTY_MIN = -DUTY_MAX - 1;
   localparam int CORR_MAX = 2**(CORR_W - 1) - 1;
   localparam int CORR_MIN = -CORR_MAX - 1;

   // register reset values
   localparam logic [RAMP_GAIN_W-1:0] RAMP_GAIN_RESET = RAMP_GAIN_W'(66);
   localparam logic [GAIN_W-1:0]      PROP_GAIN_RESET = GAIN_W'(131072);
   localparam logic [GAIN_W-1:0]      INT_GAIN_RESET  = GAIN_W'(655);
   localparam logic [GAIN_W-1:0]      WIND_GAIN_RESET = GAIN_W'(6554);
   localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = LIMIT_W'(1000);

   typedef logic signed [REF_W-1:0]  ref_type;
   typedef logic signed [CUR_W-1:0]  cur_type;
   typedef logic signed [DUTY_W-1:0] duty_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RAMP_GAIN,
      REG_PROP_GAIN,
      REG_INT_GAIN,
      REG_WINDUP_GAIN,
      REG_CURRENT_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_RAMP,
      MUL_ERR,
      MUL_RES,
      MUL_INT
   } mul_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RAMP_MUL,
      S_ERR_MUL,
      S_RES_MUL,
      S_DIFF,
      S_INT_MUL,
      S_INT_ACC,
      S_CORR,
      S_DUTY
   } state_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_load;
      logic        capture;
      logic        acc_load;
      logic        err_load;
      logic        fref_load;
      logic        diff_load;
      logic        int_load;
      logic        corr_load;
      logic        duty_load;
   } cmd_type;

   // saturate a one-bit-grown accumulator sum
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
      if (v[ACC_W] != v[ACC_W-1]) begin
         return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return v[ACC_W-1:0];
   endfunction

   // saturate a one-bit-grown integral sum
   function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W:0] v);
      if (v[INT_W] != v[INT_W-1]) begin
         return v[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
      end
      return v[INT_W-1:0];
   endfunction

   function automatic ref_type sat_fref(input logic signed [ACC_INT_W-1:0] v);
      if (v > ACC_INT_W'(REF_MAX)) begin
         return REF_W'(REF_MAX);
      end else if (v < ACC_INT_W'(REF_MIN)) begin
         return REF_W'(REF_MIN);
      end
      return REF_W'(v);
   endfunction

   function automatic logic signed [CORR_W-1:0] sat_corr(
      input logic signed [CORR_WIDE_W-1:0] v);
      if (v > CORR_WIDE_W'(CORR_MAX)) begin
         return CORR_W'(CORR_MAX);
      end else if (v < CORR_WIDE_W'(CORR_MIN)) begin
         return CORR_W'(CORR_MIN);
      end
      return CORR_W'(v);
   endfunction

   function automatic duty_type sat_duty(input logic signed [DUTY_SUM_W-1:0] v);
      if (v > DUTY_SUM_W'(DUTY_MAX)) begin
         return DUTY_W'(DUTY_MAX);
      end else if (v < DUTY_SUM_W'(DUTY_MIN)) begin
         return DUTY_W'(DUTY_MIN);
      end
      return DUTY_W'(v);
   endfunction

endpackage

// File: hw/rtl/rdcl_if.sv
// Request and response channel interfaces of the ramped drive core
`timescale 1ns / 1ps

interface rdcl_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [rdcl_pkg::REF_W-1:0] reference_a;
   logic signed [rdcl_pkg::REF_W-1:0] reference_b;
   logic signed [rdcl_pkg::REF_W-1:0] reference_c;
   logic signed [rdcl_pkg::CUR_W-1:0] current_a;
   logic signed [rdcl_pkg::CUR_W-1:0] current_b;
   logic signed [rdcl_pkg::CUR_W-1:0] current_c;
   logic                            enable;

   modport source (
      output valid, reference_a, reference_b, reference_c,
             current_a, current_b, current_c, enable,
      input  ready
   );
   modport sink (
      input  valid, reference_a, reference_b, reference_c,
             current_a, current_b, current_c, enable,
      output ready
   );
endinterface

interface rdcl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [rdcl_pkg::DUTY_W-1:0] duty_a;
   logic signed [rdcl_pkg::DUTY_W-1:0] duty_b;
   logic signed [rdcl_pkg::DUTY_W-1:0] duty_c;

   modport source (output valid, duty_a, duty_b, duty_c, input ready);
   modport sink (input valid, duty_a, duty_b, duty_c, output ready);
endinterface

// File: hw/rtl/rdcl_datapath.sv
// Datapath: configuration registers and one ramp and current-limiter lane per channel
`timescale 1ns / 1ps

module rdcl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rdcl_pkg::cmd_type                   cmd,
   input  logic                                csr_write_enable,
   input  logic [rdcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rdcl_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  rdcl_pkg::ref_type                   ref_in  [rdcl_pkg::CHANNELS],
   input  rdcl_pkg::cur_type                   cur_in  [rdcl_pkg::CHANNELS],
   output rdcl_pkg::duty_type                  duty_out [rdcl_pkg::CHANNELS]
);

   logic [rdcl_pkg::RAMP_GAIN_W-1:0] ramp_gain_ff, ramp_gain_in;
   logic [rdcl_pkg::GAIN_W-1:0]      prop_gain_ff, prop_gain_in;
   logic [rdcl_pkg::GAIN_W-1:0]      int_gain_ff, int_gain_in;
   logic [rdcl_pkg::GAIN_W-1:0]      wind_gain_ff, wind_gain_in;
   logic [rdcl_pkg::LIMIT_W-1:0]     limit_ff, limit_in;

   // decode register writes
   always_comb begin
      ramp_gain_in = ramp_gain_ff;
      prop_gain_in = prop_gain_ff;
      int_gain_in  = int_gain_ff;
      wind_gain_in = wind_gain_ff;
      limit_in     = limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rdcl_pkg::REG_RAMP_GAIN:     ramp_gain_in = rdcl_pkg::RAMP_GAIN_W'(csr_write_data);
            rdcl_pkg::REG_PROP_GAIN:     prop_gain_in = rdcl_pkg::GAIN_W'(csr_write_data);
            rdcl_pkg::REG_INT_GAIN:      int_gain_in  = rdcl_pkg::GAIN_W'(csr_write_data);
            rdcl_pkg::REG_WINDUP_GAIN:   wind_gain_in = rdcl_pkg::GAIN_W'(csr_write_data);
            rdcl_pkg::REG_CURRENT_LIMIT: limit_in     = rdcl_pkg::LIMIT_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_gain_ff <= rdcl_pkg::RAMP_GAIN_RESET;
         prop_gain_ff <= rdcl_pkg::PROP_GAIN_RESET;
         int_gain_ff  <= rdcl_pkg::INT_GAIN_RESET;
         wind_gain_ff <= rdcl_pkg::WIND_GAIN_RESET;
         limit_ff     <= rdcl_pkg::LIMIT_RESET;
      end else begin
         ramp_gain_ff <= ramp_gain_in;
         prop_gain_ff <= prop_gain_in;
         int_gain_ff  <= int_gain_in;
         wind_gain_ff <= wind_gain_in;
         limit_ff     <= limit_in;
      end
   end

   for (genvar ch = 0; ch < rdcl_pkg::CHANNELS; ch++) begin : g_lane
      rdcl_pkg::ref_type                     ref_ff;
      rdcl_pkg::cur_type                     cur_ff;
      logic signed [rdcl_pkg::ACC_W-1:0]     acc_ff, acc_in;
      rdcl_pkg::ref_type                     fref_ff, fref_in;
      logic signed [rdcl_pkg::INT_W-1:0]     int_ff, int_in;
      logic signed [rdcl_pkg::CORR_W-1:0]    corr_ff, corr_in;
      logic signed [rdcl_pkg::CORR_W-1:0]    res_ff, res_in;
      logic signed [rdcl_pkg::ERR_W-1:0]     err_ff;
      logic signed [rdcl_pkg::DIFF_W-1:0]    diff_ff;
      logic signed [rdcl_pkg::PROD_W-1:0]    prod_ff, prod_in;
      logic                                  active_ff, active_in;
      rdcl_pkg::duty_type                    duty_ff;
      logic signed [rdcl_pkg::MUL_A_W-1:0]   mul_a;
      logic signed [rdcl_pkg::MUL_B_W-1:0]   mul_b;
      logic signed [rdcl_pkg::REF_W:0]       ramp_diff;
      logic signed [rdcl_pkg::LIM_W-1:0]     lim_ext, lim_minus_cur;
      logic signed [rdcl_pkg::ACC_W:0]       acc_sum, acc_adj;
      logic signed [rdcl_pkg::ACC_INT_W-1:0] acc_int;
      logic signed [rdcl_pkg::INT_W-1:0]     int_step;
      logic signed [rdcl_pkg::INT_W:0]       int_sum, corr_sum, corr_adj;
      logic signed [rdcl_pkg::CORR_WIDE_W-1:0] corr_wide;
      logic signed [rdcl_pkg::CORR_W-1:0]    o_val;
      logic signed [rdcl_pkg::CORR_W:0]      o_ext, r_ext;
      logic signed [rdcl_pkg::DUTY_SUM_W-1:0] duty_sum;

      assign ramp_diff     = (rdcl_pkg::REF_W+1)'(ref_ff) - (rdcl_pkg::REF_W+1)'(fref_ff);
      assign lim_ext       = $signed(rdcl_pkg::LIM_W'(limit_ff));
      assign lim_minus_cur = lim_ext - rdcl_pkg::LIM_W'(cur_ff);

      // pick the multiplier operands for this step
      always_comb begin
         case (cmd.mul_sel)
            rdcl_pkg::MUL_RAMP: begin
               mul_a = rdcl_pkg::MUL_A_W'(ramp_diff);
               mul_b = $signed(rdcl_pkg::MUL_B_W'(ramp_gain_ff));
            end
            rdcl_pkg::MUL_ERR: begin
               mul_a = rdcl_pkg::MUL_A_W'(lim_minus_cur);
               mul_b = $signed(rdcl_pkg::MUL_B_W'(prop_gain_ff));
            end
            rdcl_pkg::MUL_RES: begin
               mul_a = rdcl_pkg::MUL_A_W'(res_ff);
               mul_b = $signed(rdcl_pkg::MUL_B_W'(wind_gain_ff));
            end
            rdcl_pkg::MUL_INT: begin
               mul_a = diff_ff;
               mul_b = $signed(rdcl_pkg::MUL_B_W'(int_gain_ff));
            end
            default: begin
               mul_a = diff_ff;
               mul_b = $signed(rdcl_pkg::MUL_B_W'(int_gain_ff));
            end
         endcase
      end

      assign prod_in = mul_a * mul_b;

      // ramp accumulator and its integer part, taken toward zero
      assign acc_sum = (rdcl_pkg::ACC_W+1)'(acc_ff) + (rdcl_pkg::ACC_W+1)'(prod_ff);
      assign acc_adj = (rdcl_pkg::ACC_W+1)'(acc_ff)
                     + (acc_ff[rdcl_pkg::ACC_W-1] ? (rdcl_pkg::ACC_W+1)'(rdcl_pkg::FRAC_MASK)
                                                  : (rdcl_pkg::ACC_W+1)'(0));
      assign acc_int = acc_adj[rdcl_pkg::ACC_W:rdcl_pkg::FRAC];

      // limiter integral step, floored
      assign int_step = rdcl_pkg::INT_W'(prod_ff >>> rdcl_pkg::FRAC);
      assign int_sum  = (rdcl_pkg::INT_W+1)'(int_ff) + (rdcl_pkg::INT_W+1)'(int_step);
      assign active_in = (int_ff != '0) || (rdcl_pkg::LIM_W'(cur_ff) > lim_ext);

      // raw correction, taken toward zero
      assign corr_sum  = (rdcl_pkg::INT_W+1)'(err_ff) + (rdcl_pkg::INT_W+1)'(int_ff);
      assign corr_adj  = corr_sum
                       + (corr_sum[rdcl_pkg::INT_W] ? (rdcl_pkg::INT_W+1)'(rdcl_pkg::FRAC_MASK)
                                                    : (rdcl_pkg::INT_W+1)'(0));
      assign corr_wide = corr_adj[rdcl_pkg::INT_W:rdcl_pkg::FRAC];
      assign o_val     = rdcl_pkg::sat_corr(corr_wide);
      assign o_ext     = (rdcl_pkg::CORR_W+1)'(o_val);
      assign r_ext     = (rdcl_pkg::CORR_W+1)'(fref_ff);

      // duty from the filtered reference and the correction
      assign duty_sum = fref_ff[rdcl_pkg::REF_W-1]
                      ? rdcl_pkg::DUTY_SUM_W'(fref_ff) - rdcl_pkg::DUTY_SUM_W'(corr_ff)
                      : rdcl_pkg::DUTY_SUM_W'(fref_ff) + rdcl_pkg::DUTY_SUM_W'(corr_ff);

      // next values of the lane state
      always_comb begin
         acc_in  = acc_ff;
         fref_in = fref_ff;
         int_in  = int_ff;
         corr_in = corr_ff;
         res_in  = res_ff;
         if (cmd.acc_load) begin
            acc_in = rdcl_pkg::sat_acc(acc_sum);
         end
         if (cmd.fref_load) begin
            fref_in = rdcl_pkg::sat_fref(acc_int);
         end
         if (cmd.int_load && active_in) begin
            int_in = rdcl_pkg::sat_int(int_sum);
         end
         // clamp the correction between minus the reference magnitude and zero
         if (cmd.corr_load && active_ff) begin
            corr_in = o_val;
            if (o_val > 0) begin
               res_in  = o_val;
               corr_in = '0;
            end else if (fref_ff > 0) begin
               if (o_ext < -r_ext) begin
                  res_in  = rdcl_pkg::CORR_W'(o_ext + r_ext);
                  corr_in = rdcl_pkg::CORR_W'(-r_ext);
               end
            end else if (o_ext < r_ext) begin
               res_in  = rdcl_pkg::CORR_W'(o_ext - r_ext);
               corr_in = rdcl_pkg::CORR_W'(r_ext);
            end
         end
         // drop the limiter state on a zero reference
         if (cmd.duty_load && (fref_ff == '0)) begin
            int_in  = '0;
            corr_in = '0;
            res_in  = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_ff  <= '0;
            fref_ff <= '0;
            int_ff  <= '0;
            corr_ff <= '0;
            res_ff  <= '0;
         end else begin
            acc_ff  <= acc_in;
            fref_ff <= fref_in;
            int_ff  <= int_in;
            corr_ff <= corr_in;
            res_ff  <= res_in;
         end
      end

      // working registers, no reset
      always_ff @(posedge clock) begin
         if (cmd.capture) begin
            ref_ff <= ref_in[ch];
            cur_ff <= cur_in[ch];
         end
         if (cmd.mul_load) begin
            prod_ff <= prod_in;
         end
         if (cmd.err_load) begin
            err_ff <= rdcl_pkg::ERR_W'(prod_ff);
         end
         if (cmd.diff_load) begin
            diff_ff <= rdcl_pkg::DIFF_W'(err_ff) - rdcl_pkg::DIFF_W'(prod_ff);
         end
         if (cmd.int_load) begin
            active_ff <= active_in;
         end
         if (cmd.duty_load) begin
            duty_ff <= (fref_ff == '0) ? '0 : rdcl_pkg::sat_duty(duty_sum);
         end
      end

      assign duty_out[ch] = duty_ff;
   end

endmodule

// File: hw/rtl/rdcl_ctrl.sv
// Controller: steps each request through the lane datapath and holds the response valid
`timescale 1ns / 1ps
`include "ramped_drive_with_current_limit_pi_core_assert.svh"

module rdcl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_enable,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rdcl_pkg::cmd_type cmd
);

   rdcl_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                req_take;
   logic                in_duty;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_take = req_valid && req_ready;
   assign in_duty  = (state_ff == rdcl_pkg::S_DUTY);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdcl_pkg::S_IDLE: begin
            if (req_valid && req_enable) begin
               state_in = rdcl_pkg::S_RAMP_MUL;
            end
         end
         rdcl_pkg::S_RAMP_MUL: state_in = rdcl_pkg::S_ERR_MUL;
         rdcl_pkg::S_ERR_MUL:  state_in = rdcl_pkg::S_RES_MUL;
         rdcl_pkg::S_RES_MUL:  state_in = rdcl_pkg::S_DIFF;
         rdcl_pkg::S_DIFF:     state_in = rdcl_pkg::S_INT_MUL;
         rdcl_pkg::S_INT_MUL:  state_in = rdcl_pkg::S_INT_ACC;
         rdcl_pkg::S_INT_ACC:  state_in = rdcl_pkg::S_CORR;
         rdcl_pkg::S_CORR:     state_in = rdcl_pkg::S_DUTY;
         rdcl_pkg::S_DUTY: begin
            if (out_free) begin
               state_in = rdcl_pkg::S_IDLE;
            end
         end
         default: state_in = rdcl_pkg::S_IDLE;
      endcase
   end

   // commands per state
   always_comb begin
      cmd       = '0;
      cmd.mul_sel = rdcl_pkg::MUL_RAMP;
      req_ready = 1'b0;
      case (state_ff)
         rdcl_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid && req_enable;
         end
         rdcl_pkg::S_RAMP_MUL: begin
            cmd.mul_sel  = rdcl_pkg::MUL_RAMP;
            cmd.mul_load = 1'b1;
         end
         rdcl_pkg::S_ERR_MUL: begin
            cmd.mul_sel  = rdcl_pkg::MUL_ERR;
            cmd.mul_load = 1'b1;
            cmd.acc_load = 1'b1;
         end
         rdcl_pkg::S_RES_MUL: begin
            cmd.mul_sel   = rdcl_pkg::MUL_RES;
            cmd.mul_load  = 1'b1;
            cmd.err_load  = 1'b1;
            cmd.fref_load = 1'b1;
         end
         rdcl_pkg::S_DIFF:    cmd.diff_load = 1'b1;
         rdcl_pkg::S_INT_MUL: begin
            cmd.mul_sel  = rdcl_pkg::MUL_INT;
            cmd.mul_load = 1'b1;
         end
         rdcl_pkg::S_INT_ACC: cmd.int_load  = 1'b1;
         rdcl_pkg::S_CORR:    cmd.corr_load = 1'b1;
         rdcl_pkg::S_DUTY:    cmd.duty_load = out_free;
         default: ;
      endcase
   end

   // hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.duty_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdcl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RDCL_ASSERT_SAME(a_duty_free, clock, reset, cmd.duty_load, out_free)
   `RDCL_ASSERT_NEXT(a_duty_shown, clock, reset, cmd.duty_load, rsp_valid_ff)
   `RDCL_ASSERT_NEXT(a_run, clock, reset, req_take && req_enable, state_ff == rdcl_pkg::S_RAMP_MUL)
   `RDCL_ASSERT_NEXT(a_skip, clock, reset, req_take && !req_enable, state_ff == rdcl_pkg::S_IDLE)
   `RDCL_ASSERT_NEXT(a_stall, clock, reset, in_duty && !out_free, in_duty)

endmodule

// File: hw/rtl/ramped_drive_with_current_limit_pi_core.sv
// Top level of the three-channel ramped drive with PI current limiting
//
// Channels: req_bus carries one drive tick (reference and measured current per
// channel plus enable), rsp_bus returns the three limited duties. Both use
// valid/ready; a request or response moves on a clock edge with both high.
// csr_write_enable/csr_index/csr_write_data write the gain and limit registers;
// write them only while no request is in flight.
// A request with enable clear is taken and dropped: no response, no state change.
// A taken request steps through ramp, error, residue, difference, integral
// and correction steps to the duty. The three channels run side by side, each
// lane with its own 36x20 multiplier used for four products in turn; the next
// request is taken once the previous one has reached the response register.
// Stalls: the response register holds until rsp_bus.ready; a following request
// runs through its steps meanwhile and waits in its last step for the register.
// Reset (synchronous, active high) clears the ramp and limiter state of every
// channel, drops any pending response and restores the register defaults.
`timescale 1ns / 1ps

module ramped_drive_with_current_limit_pi_core (
   input  logic                             clock,
   input  logic                             reset,
   rdcl_req_if.sink                         req_bus,
   rdcl_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [rdcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rdcl_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   rdcl_pkg::cmd_type  cmd;
   rdcl_pkg::ref_type  req_ref  [rdcl_pkg::CHANNELS];
   rdcl_pkg::cur_type  req_cur  [rdcl_pkg::CHANNELS];
   rdcl_pkg::duty_type rsp_duty [rdcl_pkg::CHANNELS];

   // gather the named channel fields into lanes
   assign req_ref[0] = req_bus.reference_a;
   assign req_ref[1] = req_bus.reference_b;
   assign req_ref[2] = req_bus.reference_c;
   assign req_cur[0] = req_bus.current_a;
   assign req_cur[1] = req_bus.current_b;
   assign req_cur[2] = req_bus.current_c;

   rdcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_enable (req_bus.enable),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .cmd        (cmd)
   );

   rdcl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ref_in           (req_ref),
      .cur_in           (req_cur),
      .duty_out         (rsp_duty)
   );

   assign rsp_bus.duty_a = rsp_duty[0];
   assign rsp_bus.duty_b = rsp_duty[1];
   assign rsp_bus.duty_c = rsp_duty[2];

endmodule

// File: sim/ramped_drive_with_current_limit_pi_core_tb.sv
// Self-checking testbench for the three-channel ramped drive core with PI current limiting
`timescale 1ns / 1ps

module ramped_drive_with_current_limit_pi_core_tb;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT      = 3000;
   localparam int SETTLE_CYCLES    = 24;
   localparam int MAX_REPORTS      = 40;
   localparam int CUR_HI           = 2**(rdcl_pkg::CUR_W - 1) - 1;
   localparam int CUR_LO           = -CUR_HI - 1;
   localparam int REF_SPAN         = 2000;
   localparam logic [rdcl_pkg::CSR_INDEX_W-1:0] SPARE_INDEX = rdcl_pkg::CSR_INDEX_W'(6);

   typedef struct packed {
      rdcl_pkg::ref_type reference_a;
      rdcl_pkg::ref_type reference_b;
      rdcl_pkg::ref_type reference_c;
      rdcl_pkg::cur_type current_a;
      rdcl_pkg::cur_type current_b;
      rdcl_pkg::cur_type current_c;
      logic              enable;
   } tick_type;

   typedef struct packed {
      rdcl_pkg::duty_type duty_a;
      rdcl_pkg::duty_type duty_b;
      rdcl_pkg::duty_type duty_c;
   } duty_set_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [rdcl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rdcl_pkg::CSR_DATA_W-1:0]  csr_write_data;

   rdcl_req_if req_bus ();
   rdcl_rsp_if rsp_bus ();

   ramped_drive_with_current_limit_pi_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of the registers
   longint gain_ramp;
   longint gain_prop;
   longint gain_int;
   longint gain_windup;
   longint limit_reg;

   // predictor copy of the per-channel state
   longint ramp_acc  [rdcl_pkg::CHANNELS];
   longint fref      [rdcl_pkg::CHANNELS];
   longint lim_int   [rdcl_pkg::CHANNELS];
   longint lim_corr  [rdcl_pkg::CHANNELS];
   longint lim_resid [rdcl_pkg::CHANNELS];

   duty_set_type duty_queue [$];

   bit idle_on   = 1'b1;
   bit long_hold = 1'b0;
   int mismatches        = 0;
   int ticks_enabled     = 0;
   int ticks_ignored     = 0;
   int duty_sets_checked = 0;
   int settings_loaded   = 0;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint sat_to(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   task automatic reset_drive_model();
      gain_ramp   = longint'(rdcl_pkg::RAMP_GAIN_RESET);
      gain_prop   = longint'(rdcl_pkg::PROP_GAIN_RESET);
      gain_int    = longint'(rdcl_pkg::INT_GAIN_RESET);
      gain_windup = longint'(rdcl_pkg::WIND_GAIN_RESET);
      limit_reg   = longint'(rdcl_pkg::LIMIT_RESET);
      for (int i = 0; i < rdcl_pkg::CHANNELS; i++) begin
         ramp_acc[i]  = 0;
         fref[i]      = 0;
         lim_int[i]   = 0;
         lim_corr[i]  = 0;
         lim_resid[i] = 0;
      end
   endtask

   // advance every channel by one enabled tick and return the duties it yields
   function automatic duty_set_type step_drive(input tick_type t);
      longint       refv [rdcl_pkg::CHANNELS];
      longint       curv [rdcl_pkg::CHANNELS];
      longint       duty [rdcl_pkg::CHANNELS];
      longint       scale;
      longint       r;
      longint       o;
      longint       err;
      longint       drive;
      duty_set_type d;
      scale   = longint'(1) <<< rdcl_pkg::FRAC;
      refv[0] = longint'(signed'(t.reference_a));
      refv[1] = longint'(signed'(t.reference_b));
      refv[2] = longint'(signed'(t.reference_c));
      curv[0] = longint'(signed'(t.current_a));
      curv[1] = longint'(signed'(t.current_b));
      curv[2] = longint'(signed'(t.current_c));
      for (int i = 0; i < rdcl_pkg::CHANNELS; i++) begin
         // first-order ramp toward the reference
         ramp_acc[i] = sat_to(ramp_acc[i] + gain_ramp * (refv[i] - fref[i]), rdcl_pkg::ACC_W);
         fref[i]     = sat_to(ramp_acc[i] / scale, rdcl_pkg::REF_W);
         r           = fref[i];
         // limiter runs while winding down or while over the limit
         if (lim_int[i] != 0 || curv[i] > limit_reg) begin
            err        = (limit_reg - curv[i]) * gain_prop;
            drive      = (err - lim_resid[i] * gain_windup) * gain_int;
            lim_int[i] = sat_to(lim_int[i] + (drive >>> rdcl_pkg::FRAC), rdcl_pkg::INT_W);
            o          = sat_to((err + lim_int[i]) / scale, rdcl_pkg::CORR_W);
            if (o > 0) begin
               lim_resid[i] = o;
               o = 0;
            end else if (r > 0) begin
               if (o < -r) begin
                  lim_resid[i] = o + r;
                  o = -r;
               end
            end else begin
               if (o < r) begin
                  lim_resid[i] = o - r;
                  o = r;
               end
            end
            lim_corr[i] = o;
         end
         // apply the correction toward zero; a zero reference clears the limiter
         if (r < 0) begin
            duty[i] = r - lim_corr[i];
         end else if (r > 0) begin
            duty[i] = r + lim_corr[i];
         end else begin
            lim_int[i]   = 0;
            lim_corr[i]  = 0;
            lim_resid[i] = 0;
            duty[i]      = 0;
         end
         duty[i] = sat_to(duty[i], rdcl_pkg::DUTY_W);
      end
      d.duty_a = rdcl_pkg::duty_type'(duty[0]);
      d.duty_b = rdcl_pkg::duty_type'(duty[1]);
      d.duty_c = rdcl_pkg::duty_type'(duty[2]);
      return d;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("tb: mismatch at %0t ns: %s", $time, what);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return $urandom_range(1, 3);
      if (p < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic tick_type make_tick(input int ra, input int rb, input int rc,
                                          input int ca, input int cb, input int cc,
                                          input bit en);
      tick_type t;
      t.reference_a = rdcl_pkg::ref_type'(ra);
      t.reference_b = rdcl_pkg::ref_type'(rb);
      t.reference_c = rdcl_pkg::ref_type'(rc);
      t.current_a   = rdcl_pkg::cur_type'(ca);
      t.current_b   = rdcl_pkg::cur_type'(cb);
      t.current_c   = rdcl_pkg::cur_type'(cc);
      t.enable      = en;
      return t;
   endfunction

   function automatic int rand_reference();
      return int'($urandom_range(0, 2 * REF_SPAN)) - REF_SPAN;
   endfunction

   function automatic int rand_current();
      return int'($urandom_range(0, 2 * CUR_HI + 1)) + CUR_LO;
   endfunction

   // mostly close to the limit so that the limiter engages and releases
   function automatic int drive_current();
      int c;
      if ($urandom_range(0, 99) < 65) begin
         c = int'(limit_reg) + int'($urandom_range(0, 600)) - 300;
      end else begin
         c = rand_current();
      end
      if (c > CUR_HI) c = CUR_HI;
      if (c < CUR_LO) c = CUR_LO;
      return c;
   endfunction

   function automatic tick_type noise_tick();
      return make_tick(rand_reference(), rand_reference(), rand_reference(),
                       rand_current(), rand_current(), rand_current(),
                       $urandom_range(0, 1) == 1);
   endfunction

   // offer one request, hold it until taken, then predict its duties
   task automatic send_tick(input tick_type t);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.reference_a <= t.reference_a;
      req_bus.reference_b <= t.reference_b;
      req_bus.reference_c <= t.reference_c;
      req_bus.current_a   <= t.current_a;
      req_bus.current_b   <= t.current_b;
      req_bus.current_c   <= t.current_c;
      req_bus.enable      <= t.enable;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (t.enable) begin
         duty_queue.push_back(step_drive(t));
         ticks_enabled++;
      end else begin
         ticks_ignored++;
      end
      gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, let every pending duty arrive, then let an ignored request clear
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rdcl_pkg::CSR_INDEX_W-1:0] reg_index,
                            input logic [rdcl_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= value;
      @(posedge clock);
      case (reg_index)
         rdcl_pkg::REG_RAMP_GAIN:
            gain_ramp   = longint'(value[rdcl_pkg::RAMP_GAIN_W-1:0]);
         rdcl_pkg::REG_PROP_GAIN:
            gain_prop   = longint'(value[rdcl_pkg::GAIN_W-1:0]);
         rdcl_pkg::REG_INT_GAIN:
            gain_int    = longint'(value[rdcl_pkg::GAIN_W-1:0]);
         rdcl_pkg::REG_WINDUP_GAIN:
            gain_windup = longint'(value[rdcl_pkg::GAIN_W-1:0]);
         rdcl_pkg::REG_CURRENT_LIMIT:
            limit_reg   = longint'(value[rdcl_pkg::LIMIT_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic load_settings(input int ramp, input int prop, input int integ,
                                input int windup, input int lim, input bit spare);
      wait_idle();
      csr_write(rdcl_pkg::REG_RAMP_GAIN, rdcl_pkg::CSR_DATA_W'(ramp));
      csr_write(rdcl_pkg::REG_PROP_GAIN, rdcl_pkg::CSR_DATA_W'(prop));
      csr_write(rdcl_pkg::REG_INT_GAIN, rdcl_pkg::CSR_DATA_W'(integ));
      csr_write(rdcl_pkg::REG_WINDUP_GAIN, rdcl_pkg::CSR_DATA_W'(windup));
      csr_write(rdcl_pkg::REG_CURRENT_LIMIT, rdcl_pkg::CSR_DATA_W'(lim));
      // a write past the last register must change nothing
      if (spare) csr_write(SPARE_INDEX, rdcl_pkg::CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   // runs of held references with varied currents, mixed with noise
   task automatic run_ticks(input int count);
      int       sent;
      int       hold;
      int       p;
      int       base [rdcl_pkg::CHANNELS];
      tick_type t;
      sent = 0;
      while (sent < count) begin
         for (int k = 0; k < rdcl_pkg::CHANNELS; k++) begin
            base[k] = ($urandom_range(0, 9) == 0) ? 0 : rand_reference();
         end
         hold = $urandom_range(3, 14);
         for (int h = 0; h < hold && sent < count; h++) begin
            p = $urandom_range(0, 99);
            if (p < 10) begin
               t = noise_tick();
            end else begin
               t = make_tick(base[0], base[1], base[2],
                             drive_current(), drive_current(), drive_current(), p >= 14);
            end
            send_tick(t);
            if (t.enable) sent++;
         end
      end
   endtask

   // field extremes and the limiter corner cases, in a fixed order
   task automatic test_directed();
      // defaults from reset
      send_tick(make_tick(2000, 2000, 2000, 4095, 4095, 4095, 1'b0));
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 1'b1));
      send_tick(make_tick(2000, -2000, 0, 4095, 4095, -4096, 1'b1));
      send_tick(make_tick(2000, -2000, 1000, -4096, 4095, 1001, 1'b1));
      send_tick(make_tick(-1, 1, -2000, -4096, -4096, -4096, 1'b0));
      // fast ramp: clamp below minus the magnitude, positive correction, wind-down
      load_settings(65535, 131072, 655, 6554, 1000, 1'b0);
      send_tick(make_tick(2000, -2000, 500, 4095, 4095, 4095, 1'b1));
      send_tick(make_tick(2000, -2000, 500, 1001, 1001, 1001, 1'b1));
      send_tick(make_tick(2000, -2000, 500, -4096, -4096, -4096, 1'b1));
      send_tick(make_tick(2000, -2000, 500, 0, 0, 0, 1'b1));
      send_tick(make_tick(0, 0, 0, 4095, 4095, 4095, 1'b1));
      send_tick(make_tick(-2000, 2000, -1, 4095, 4095, 4095, 1'b1));
      send_tick(make_tick(-2000, 2000, -1, 500, 500, 500, 1'b1));
      // no integral: a stale correction is reused once the current falls
      load_settings(65535, 131072, 0, 0, 1000, 1'b0);
      send_tick(make_tick(1500, -1500, 800, 4095, 4095, 4095, 1'b1));
      send_tick(make_tick(-1500, 1500, -800, 0, 0, 0, 1'b1));
      send_tick(make_tick(2000, -2000, 2000, 0, 0, 0, 1'b1));
      send_tick(make_tick(2000, -2000, 2000, 4095, 4095, 4095, 1'b0));
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 1'b1));
   endtask

   task automatic test_register_extremes();
      // all-ones data, masked down to each register width
      load_settings(-1, -1, -1, -1, -1, 1'b1);
      run_ticks(25);
      load_settings(0, 0, 0, 0, 0, 1'b0);
      run_ticks(25);
      load_settings(65535, 131072, 0, 0, 0, 1'b1);
      run_ticks(25);
      load_settings(40000, 524287, 524287, 0, 2047, 1'b0);
      run_ticks(25);
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 8; ph++) begin
         // one phase runs with no idling on either side
         idle_on = (ph != 3);
         load_settings(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000)
                                                   : $urandom_range(2000, 65535),
                       $urandom_range(0, 524287),
                       ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20000)
                                                   : $urandom_range(0, 524287),
                       $urandom_range(0, 524287),
                       $urandom_range(0, 4095),
                       $urandom_range(0, 1) == 1);
         run_ticks(30);
      end
      idle_on = 1'b1;
   endtask

   // stall the responses for a long stretch while requests keep coming
   task automatic test_backpressure();
      idle_on   = 1'b0;
      long_hold = 1'b1;
      run_ticks(30);
      idle_on   = 1'b1;
   endtask

   // pause the requests until every duty has come back, then resume
   task automatic test_sender_pause();
      run_ticks(20);
      wait_idle();
      run_ticks(20);
   endtask

   // response side: random stalls, plus a long hold on demand
   initial begin : response_sink
      int gap;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < 30) begin
            rsp_bus.ready <= 1'b0;
            gap = idle_gap();
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each response with the oldest predicted duty set
   always @(posedge clock) begin : duty_checker
      duty_set_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (duty_queue.size() == 0) begin
            report_mismatch("response with no enabled request pending");
         end else begin
            want = duty_queue.pop_front();
            duty_sets_checked++;
            if (rsp_bus.duty_a !== want.duty_a)
               report_mismatch($sformatf("duty_a %0d, predicted %0d",
                                         rsp_bus.duty_a, want.duty_a));
            if (rsp_bus.duty_b !== want.duty_b)
               report_mismatch($sformatf("duty_b %0d, predicted %0d",
                                         rsp_bus.duty_b, want.duty_b));
            if (rsp_bus.duty_c !== want.duty_c)
               report_mismatch($sformatf("duty_c %0d, predicted %0d",
                                         rsp_bus.duty_c, want.duty_c));
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : stall_watchdog
      int idle_count;
      idle_count = 0;
      while (idle_count < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_count = 0;
         end else begin
            idle_count++;
         end
      end
      $display("tb: stalled for %0d cycles with %0d duty sets pending",
               STALL_LIMIT, duty_queue.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset_drive_model();
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.reference_a <= '0;
      req_bus.reference_b <= '0;
      req_bus.reference_c <= '0;
      req_bus.current_a   <= '0;
      req_bus.current_b   <= '0;
      req_bus.current_c   <= '0;
      req_bus.enable      <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      test_sender_pause();
      wait_idle();

      $display("tb: %0d enabled and %0d ignored requests, %0d duty sets checked",
               ticks_enabled, ticks_ignored, duty_sets_checked);
      $display("tb: %0d register settings incl. gain and limit extremes, long output stall",
               settings_loaded);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
